@@ rtl/assert_macros.svh @@
// Assertion helpers for the name decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define DLNE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define DLNE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/dlne_pkg.sv @@
`timescale 1ns / 1ps

package dlne_pkg;

  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam logic [7:0] NAME_LIMIT_RST = 8'd255;
  localparam logic [7:0] CH_DOT         = 8'h2e;
  localparam logic [7:0] CH_QMARK       = 8'h3f;
  localparam logic [7:0] CH_UNDERSCORE  = 8'h5f;
  localparam logic [7:0] CH_CASE_DELTA  = 8'h20;
  localparam logic [7:0] CH_UPPER_A     = 8'h41;
  localparam logic [7:0] CH_UPPER_Z     = 8'h5a;
  localparam logic [7:0] CH_PRINT_LO    = 8'h20;
  localparam logic [7:0] CH_PRINT_HI    = 8'h7e;

  localparam logic [31:0] ALLOW_DIGITS = 32'h03ff2000;
  localparam logic [31:0] ALLOW_UPPER  = 32'h87fffffe;
  localparam logic [31:0] ALLOW_LOWER  = 32'h07fffffe;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_DROP = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_LABEL = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [5:0]  label_left;
    logic [15:0] remaining;
    logic [7:0]  char_count;
    logic        valid_flag;
    logic        relaxed_mode;
  } state_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic [7:0] name_length;
    logic       name_valid;
    logic       last;
  } res_t;

  function automatic logic char_ok(input logic [7:0] c);
    logic ok;
    ok = 1'b0;
    if (!c[7]) begin
      unique case (c[6:5])
        2'd0: ok = 1'b0;
        2'd1: ok = ALLOW_DIGITS[c[4:0]];
        2'd2: ok = ALLOW_UPPER[c[4:0]];
        2'd3: ok = ALLOW_LOWER[c[4:0]];
        default: ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

endpackage

@@ rtl/dlne_step.sv @@
`timescale 1ns / 1ps

module dlne_step (
  input  dlne_pkg::state_t st_q_i,
  input  logic [7:0]       name_limit_i,
  input  logic [7:0]       data_byte_i,
  input  logic             first_i,
  input  logic [15:0]      bytes_left_i,
  input  logic             relaxed_i,
  output dlne_pkg::state_t st_d_o,
  output dlne_pkg::res_t   res0_o,
  output dlne_pkg::res_t   res1_o,
  output logic [1:0]       n_res_o
);

  dlne_pkg::state_t st_e;
  logic             active;
  logic [7:0]       cnt_inc;
  logic [7:0]       lower;
  logic [7:0]       ch;
  logic             vf_new;
  logic [5:0]       ll_new;

  always_comb begin
    st_e = st_q_i;
    if (first_i) begin
      st_e.remaining    = bytes_left_i;
      st_e.relaxed_mode = relaxed_i;
      st_e.char_count   = '0;
      st_e.valid_flag   = 1'b1;
      st_e.label_left   = '0;
      st_e.phase        = dlne_pkg::PH_LEN;
    end
    active = first_i || (st_q_i.phase == dlne_pkg::PH_LEN)
                     || (st_q_i.phase == dlne_pkg::PH_LABEL);

    cnt_inc = st_e.char_count + 8'd1;
    lower   = ((data_byte_i >= dlne_pkg::CH_UPPER_A) && (data_byte_i <= dlne_pkg::CH_UPPER_Z))
            ? (data_byte_i + dlne_pkg::CH_CASE_DELTA) : data_byte_i;
    vf_new  = st_e.valid_flag;
    if (st_e.relaxed_mode || dlne_pkg::char_ok(data_byte_i)) begin
      ch = lower;
    end else begin
      vf_new = 1'b0;
      ch = ((data_byte_i < dlne_pkg::CH_PRINT_LO) || (data_byte_i > dlne_pkg::CH_PRINT_HI))
         ? dlne_pkg::CH_QMARK : dlne_pkg::CH_UNDERSCORE;
    end
    ll_new = (st_e.label_left != 6'd0) ? (st_e.label_left - 6'd1) : 6'd0;

    st_d_o  = st_q_i;
    res0_o  = '0;
    res1_o  = '0;
    n_res_o = 2'd0;

    if (active) begin
      st_d_o = st_e;
      if ((st_e.char_count >= name_limit_i)
          || ((st_e.phase == dlne_pkg::PH_LEN) && (st_e.remaining == 16'd0))) begin
        res0_o  = '{dlne_pkg::KIND_END, 8'd0, st_e.char_count, st_e.valid_flag, 1'b1};
        n_res_o = 2'd1;
        st_d_o.phase = dlne_pkg::PH_DONE;
      end else if (st_e.phase == dlne_pkg::PH_LEN) begin
        if (data_byte_i == 8'd0) begin
          res0_o  = '{dlne_pkg::KIND_END, 8'd0, st_e.char_count, st_e.valid_flag, 1'b1};
          n_res_o = 2'd1;
          st_d_o.phase = dlne_pkg::PH_DONE;
        end else if ((data_byte_i[7:6] != 2'b00)
                     || (({8'd0, data_byte_i} + 16'd1) >= st_e.remaining)) begin
          res0_o  = '{dlne_pkg::KIND_DROP, 8'd0, 8'd0, st_e.valid_flag, 1'b1};
          n_res_o = 2'd1;
          st_d_o.char_count = '0;
          st_d_o.phase      = dlne_pkg::PH_DONE;
        end else begin
          st_d_o.remaining  = st_e.remaining - 16'd1;
          st_d_o.label_left = data_byte_i[5:0];
          st_d_o.phase      = dlne_pkg::PH_LABEL;
          if (st_e.char_count != 8'd0) begin
            st_d_o.char_count = cnt_inc;
            res0_o  = '{dlne_pkg::KIND_CHAR, dlne_pkg::CH_DOT, cnt_inc, st_e.valid_flag, 1'b1};
            n_res_o = 2'd1;
            if (cnt_inc >= name_limit_i) begin
              res0_o.last  = 1'b0;
              res1_o  = '{dlne_pkg::KIND_END, 8'd0, cnt_inc, st_e.valid_flag, 1'b1};
              n_res_o = 2'd2;
              st_d_o.phase = dlne_pkg::PH_DONE;
            end
          end
        end
      end else begin
        st_d_o.char_count = cnt_inc;
        st_d_o.valid_flag = vf_new;
        st_d_o.label_left = ll_new;
        if (st_e.remaining != 16'd0) begin
          st_d_o.remaining = st_e.remaining - 16'd1;
        end
        res0_o  = '{dlne_pkg::KIND_CHAR, ch, cnt_inc, vf_new, 1'b1};
        n_res_o = 2'd1;
        if (cnt_inc >= name_limit_i) begin
          res0_o.last  = 1'b0;
          res1_o  = '{dlne_pkg::KIND_END, 8'd0, cnt_inc, vf_new, 1'b1};
          n_res_o = 2'd2;
          st_d_o.phase = dlne_pkg::PH_DONE;
        end else if (ll_new == 6'd0) begin
          st_d_o.phase = dlne_pkg::PH_LEN;
        end
      end
    end
  end

endmodule

@@ rtl/dlne_outq.sv @@
`timescale 1ns / 1ps

module dlne_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     push_n_i,
  input  dlne_pkg::res_t push0_i,
  input  dlne_pkg::res_t push1_i,
  input  logic           pop_i,
  output logic           room_o,
  output logic           valid_o,
  output dlne_pkg::res_t head_o,
  output logic [dlne_pkg::OQ_CNT_W-1:0] count_o
);

  dlne_pkg::res_t                 mem_q [dlne_pkg::OQ_DEPTH];
  logic [dlne_pkg::OQ_PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [dlne_pkg::OQ_CNT_W-1:0]  cnt_q, cnt_d;
  logic                           do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign wr_nxt  = wr_q + dlne_pkg::OQ_PTR_W'(1);
  assign wr_d    = wr_q + dlne_pkg::OQ_PTR_W'(push_n_i);
  assign rd_d    = rd_q + dlne_pkg::OQ_PTR_W'(do_pop);
  assign cnt_d   = cnt_q + dlne_pkg::OQ_CNT_W'(push_n_i) - dlne_pkg::OQ_CNT_W'(do_pop);
  assign room_o  = cnt_q <= dlne_pkg::OQ_CNT_W'(dlne_pkg::OQ_DEPTH - 2);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_nxt] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/dns_label_name_extractor_unit.sv @@
// Results of an accepted request are registered in the result queue and leave from its head.
// Throughput: one request per cycle while the result queue has room for two results; a
// request that yields two results (dot or character plus end) is absorbed by a 4-entry result queue.
// Reset: name_limit returns to 255, decoder idles until a byte with first set,
// result queue empties.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dns_label_name_extractor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // name_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // [7:0] data_byte, [23:8] bytes_left
  input  logic [1:0]  s_axis_tuser,    // [0] first, [1] relaxed
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,    // [7:0] out_char, [15:8] name_length
  output logic [2:0]  m_axis_tuser,    // [1:0] kind, [2] name_valid
  output logic        m_axis_tlast
);

  logic [7:0]       limit_q;
  dlne_pkg::state_t st_q, st_d;
  dlne_pkg::res_t   res0, res1, head;
  logic [1:0]       n_res;
  logic             s_acc;
  logic             room;
  logic [dlne_pkg::OQ_CNT_W-1:0] q_count;

  assign s_acc         = s_axis_tvalid && room;
  assign s_axis_tready = room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= dlne_pkg::NAME_LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{dlne_pkg::PH_IDLE, 6'd0, 16'd0, 8'd0, 1'b1, 1'b0};
    end else if (s_acc) begin
      st_q <= st_d;
    end
  end

  dlne_step u_step (
    .st_q_i       (st_q),
    .name_limit_i (limit_q),
    .data_byte_i  (s_axis_tdata[7:0]),
    .first_i      (s_axis_tuser[0]),
    .bytes_left_i (s_axis_tdata[23:8]),
    .relaxed_i    (s_axis_tuser[1]),
    .st_d_o       (st_d),
    .res0_o       (res0),
    .res1_o       (res1),
    .n_res_o      (n_res)
  );

  dlne_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (s_acc ? n_res : 2'd0),
    .push0_i  (res0),
    .push1_i  (res1),
    .pop_i    (m_axis_tready),
    .room_o   (room),
    .valid_o  (m_axis_tvalid),
    .head_o   (head),
    .count_o  (q_count)
  );

  assign m_axis_tdata = {head.name_length, head.ch};
  assign m_axis_tuser = {head.name_valid, head.kind};
  assign m_axis_tlast = head.last;

  `DLNE_ASSERT(a_q_bound, clk_i, rst_ni,
    q_count <= dlne_pkg::OQ_CNT_W'(dlne_pkg::OQ_DEPTH), "result queue overflow")
  `DLNE_ASSERT(a_drop_len, clk_i, rst_ni,
    (m_axis_tvalid && (head.kind == dlne_pkg::KIND_DROP)) |-> (head.name_length == 8'd0),
    "discarded name reports nonzero length")
  `DLNE_ASSERT(a_two_ends, clk_i, rst_ni,
    (s_acc && (n_res == 2'd2)) |-> (!res0.last && res1.last && (res1.kind == dlne_pkg::KIND_END)),
    "two-result request not closed by end result")
  `DLNE_ASSERT_ALWAYS(a_rst_idle, clk_i,
    !rst_ni |=> (!m_axis_tvalid || !rst_ni), "results visible after reset")

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;

  class name_scoreboard;
    logic [7:0]        limit;
    dlne_pkg::phase_e  phase;
    logic [5:0]        label_left;
    logic [15:0]       remaining;
    logic [7:0]        char_count;
    logic              valid_flag;
    logic              relaxed_mode;
    dlne_pkg::res_t    expected_q[$];
    int                errors;

    function new();
      limit        = dlne_pkg::NAME_LIMIT_RST;
      phase        = dlne_pkg::PH_IDLE;
      label_left   = '0;
      remaining    = '0;
      char_count   = '0;
      valid_flag   = 1'b1;
      relaxed_mode = 1'b0;
      errors       = 0;
    endfunction

    function void set_limit(logic [7:0] value);
      limit = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void add_result(dlne_pkg::kind_e kind, logic [7:0] ch, logic last);
      dlne_pkg::res_t r;
      r.kind        = kind;
      r.ch          = ch;
      r.name_length = char_count;
      r.name_valid  = valid_flag;
      r.last        = last;
      expected_q.push_back(r);
    endfunction

    // lower-case letters; in strict mode flag and replace disallowed characters
    function logic [7:0] fold_char(logic [7:0] c);
      logic [7:0] lower;
      logic       ok;
      lower = (c >= dlne_pkg::CH_UPPER_A && c <= dlne_pkg::CH_UPPER_Z)
            ? c + dlne_pkg::CH_CASE_DELTA : c;
      ok = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == "-" || c == "_";
      if (relaxed_mode || ok) return lower;
      valid_flag = 1'b0;
      return (c < dlne_pkg::CH_PRINT_LO || c > dlne_pkg::CH_PRINT_HI)
             ? dlne_pkg::CH_QMARK : dlne_pkg::CH_UNDERSCORE;
    endfunction

    // returns 1 when the request is consumed by a name
    function bit note_request(logic [7:0] b, logic first, logic [15:0] left, logic relaxed);
      logic [7:0] ch;
      if (first) begin
        remaining    = left;
        relaxed_mode = relaxed;
        char_count   = '0;
        valid_flag   = 1'b1;
        label_left   = '0;
        phase        = dlne_pkg::PH_LEN;
      end else if (phase != dlne_pkg::PH_LEN && phase != dlne_pkg::PH_LABEL) begin
        return 1'b0;
      end
      if (char_count >= limit || (phase == dlne_pkg::PH_LEN && remaining == 0)) begin
        add_result(dlne_pkg::KIND_END, 8'h00, 1'b1);
        phase = dlne_pkg::PH_DONE;
        return 1'b1;
      end
      if (phase == dlne_pkg::PH_LEN) begin
        if (b == 8'h00) begin
          add_result(dlne_pkg::KIND_END, 8'h00, 1'b1);
          phase = dlne_pkg::PH_DONE;
          return 1'b1;
        end
        if (b[7:6] != 2'b00 || int'(b) + 1 >= int'(remaining)) begin
          char_count = '0;
          add_result(dlne_pkg::KIND_DROP, 8'h00, 1'b1);
          phase = dlne_pkg::PH_DONE;
          return 1'b1;
        end
        remaining--;
        if (char_count != 0) begin
          char_count++;
          if (char_count >= limit) begin
            add_result(dlne_pkg::KIND_CHAR, dlne_pkg::CH_DOT, 1'b0);
            add_result(dlne_pkg::KIND_END, 8'h00, 1'b1);
            phase = dlne_pkg::PH_DONE;
            return 1'b1;
          end
          add_result(dlne_pkg::KIND_CHAR, dlne_pkg::CH_DOT, 1'b1);
        end
        label_left = b[5:0];
        phase      = dlne_pkg::PH_LABEL;
        return 1'b1;
      end
      ch = fold_char(b);
      char_count++;
      if (label_left != 0) label_left--;
      if (remaining != 0) remaining--;
      if (char_count >= limit) begin
        add_result(dlne_pkg::KIND_CHAR, ch, 1'b0);
        add_result(dlne_pkg::KIND_END, 8'h00, 1'b1);
        phase = dlne_pkg::PH_DONE;
        return 1'b1;
      end
      add_result(dlne_pkg::KIND_CHAR, ch, 1'b1);
      if (label_left == 0) phase = dlne_pkg::PH_LEN;
      return 1'b1;
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    function void check_result(dlne_pkg::res_t got);
      dlne_pkg::res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind) report("kind", want.kind, got.kind);
      if (got.ch !== want.ch) report("out_char", want.ch, got.ch);
      if (got.name_length !== want.name_length)
        report("name_length", want.name_length, got.name_length);
      if (got.name_valid !== want.name_valid)
        report("name_valid", want.name_valid, got.name_valid);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;    // [7:0] data_byte, [23:8] bytes_left
  logic [1:0]  s_axis_tuser;    // [0] first, [1] relaxed
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;    // [7:0] out_char, [15:8] name_length
  logic [2:0]  m_axis_tuser;    // [1:0] kind, [2] name_valid
  logic        m_axis_tlast;

  name_scoreboard sb = new();
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int items_done = 0;
  int cycle_count = 0;

  dns_label_name_extractor_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check accepted results, stall at random or for a requested hold
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    dlne_pkg::res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind        = dlne_pkg::kind_e'(m_axis_tuser[1:0]);
      got.ch          = m_axis_tdata[7:0];
      got.name_length = m_axis_tdata[15:8];
      got.name_valid  = m_axis_tuser[2];
      got.last        = m_axis_tlast;
      sb.check_result(got);
    end
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = 250;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic first, input logic [15:0] left,
                           input logic relaxed);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {left, b};
    s_axis_tuser  <= {relaxed, first};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    void'(sb.note_request(b, first, left, relaxed));
    items_done++;
  endtask

  // continuation byte; bytes_left and relaxed must be ignored here
  task automatic send_cont(input logic [7:0] b);
    send_item(b, 1'b0, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drain(input int settle);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(value);
  endtask

  function automatic logic [7:0] rand_label_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 8'($urandom_range(8'h61, 8'h7a));
    if (pick < 60) return 8'($urandom_range(8'h41, 8'h5a));
    if (pick < 75) return 8'($urandom_range(8'h30, 8'h39));
    if (pick < 80) return ($urandom_range(0, 1) != 0) ? 8'h2d : 8'h5f;
    return 8'($urandom_range(0, 255));
  endfunction

  // one name: mostly well formed, some with a pointer, a short packet or cut off
  task automatic gen_name();
    logic [7:0]  name_q[$];
    logic [15:0] left;
    logic        relaxed;
    int          flavor;
    int          nlabels;
    int          len;
    int          cut;
    bit          full;
    flavor  = $urandom_range(0, 19);
    full    = ($urandom_range(0, 39) == 0);
    relaxed = ($urandom_range(0, 3) == 0);
    nlabels = full ? 5 : $urandom_range(1, 4);
    for (int i = 0; i < nlabels; i++) begin
      len = full ? 63 : (($urandom_range(0, 9) == 0) ? $urandom_range(1, 63)
                                                      : $urandom_range(1, 8));
      name_q.push_back(8'(len));
      repeat (len) name_q.push_back(rand_label_char());
    end
    name_q.push_back(8'h00);
    if (flavor == 0) begin
      name_q[name_q.size() - 1] = 8'($urandom_range(64, 255));
    end else if (flavor == 2) begin
      cut = $urandom_range(1, name_q.size() - 1);
      while (name_q.size() > cut) void'(name_q.pop_back());
    end
    if (flavor == 1) left = 16'($urandom_range(0, name_q.size()));
    else if ($urandom_range(0, 7) == 0) left = 16'($urandom_range(name_q.size() + 1, 65535));
    else left = 16'(name_q.size() + $urandom_range(1, 200));
    foreach (name_q[i]) begin
      if (i == 0) send_item(name_q[i], 1'b1, left, relaxed);
      else send_cont(name_q[i]);
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_cont(8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [7:0] limit_plan [8];
    int         target;
    limit_plan = '{8'd255, 8'd1, 8'd12, 8'd255, 8'd2, 8'd40, 8'd7, 8'd255};
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // strict name: dot, upper case, unprintable and printable replacements
    send_item(8'h03, 1'b1, 16'hffff, 1'b0);
    send_cont("Z");
    send_cont("_");
    send_cont("9");
    send_cont(8'h02);
    send_cont(8'h7f);
    send_cont("*");
    send_cont(8'h00);
    send_cont(8'haa);
    // nothing left in the packet, compression pointer, label past packet end
    send_item(8'hff, 1'b1, 16'h0000, 1'b1);
    send_item(8'hc0, 1'b1, 16'd50, 1'b0);
    send_item(8'h05, 1'b1, 16'd6, 1'b1);
    // restart in the middle of a name, relaxed mode keeps odd bytes
    send_item(8'h03, 1'b1, 16'd10, 1'b0);
    send_cont("a");
    send_item(8'h01, 1'b1, 16'h8000, 1'b1);
    send_cont(8'hff);
    send_cont(8'h00);
    // discarded name keeps the cleared valid flag
    send_item(8'h02, 1'b1, 16'd100, 1'b0);
    send_cont(8'h00);
    send_cont("k");
    send_cont(8'h43);
    // dot fills the limit
    wait_drain(4);
    write_limit(8'd3);
    send_item(8'h02, 1'b1, 16'd100, 1'b0);
    send_cont("a");
    send_cont("b");
    send_cont(8'h01);
    // limit lowered below the count of a name in progress
    wait_drain(4);
    write_limit(8'd255);
    send_item(8'h05, 1'b1, 16'd100, 1'b0);
    send_cont("a");
    send_cont("b");
    send_cont("c");
    wait_drain(4);
    write_limit(8'd2);
    send_cont("d");
    // zero limit ends at once
    wait_drain(4);
    write_limit(8'd0);
    send_item(8'h10, 1'b1, 16'd100, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drain(4);
      write_limit(limit_plan[ph]);
      idle_pct  = (ph % 4 == 1) ? 48 : (ph % 4 == 3) ? 31 : 0;
      stall_pct = (ph % 4 == 2) ? 48 : (ph % 4 == 3) ? 31 : 0;
      if (ph == 0 || ph == 3) hold_reqs++;
      target = items_done + 140;
      while (items_done < target) begin
        gen_name();
        if (ph == 4 && $urandom_range(0, 9) == 0) wait_drain(1);
      end
    end

    wait_drain(10);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
